// ----- rtl/lras_pkg.sv -----
// ----------------------------------------------------------------------------
// lras_pkg
// Types and codes shared by the lazy range add / range sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package lras_pkg;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUM = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam int       CSR_AW        = 3;
   localparam logic [2:0] CSR_SIZE_ADDR = 3'd0;

   localparam int SIZE_W  = 11;
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 64;

   typedef struct packed {
      logic                      opcode;
      logic [INDEX_W-1:0]        left_index;
      logic [INDEX_W-1:0]        right_index;
      logic signed [VALUE_W-1:0] increment;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] range_sum;
      logic                      status;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/lazy_range_add_range_sum.sv -----
// ----------------------------------------------------------------------------
// lazy_range_add_range_sum
// Segment tree with lazy pending adds kept in two node memories; a sequencer
// walks the tree with an explicit frame stack, one node access at a time.
// ----------------------------------------------------------------------------
// Bad range: answered in the cycle after start. A good item visits each covered
//   node and each split node (pending push, sum fix-up) in turn.
// Throughput: one item at a time; start is taken again once busy drops.
// Reset: a clearing pass over all DEPTH addresses zeroes both node memories,
//   busy stays high meanwhile. Results cannot be stalled.
`default_nettype none

module lazy_range_add_range_sum #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  lras_pkg::req_type       req_data,
   output logic                          rsp_valid,
   output lras_pkg::rsp_type             rsp_data,
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire  [lras_pkg::CSR_AW-1:0]   paddr,
   input  wire  [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int DEPTH = 4 * MAX_ELEMENTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW0   = $clog2(MAX_ELEMENTS + 1);
   localparam int NW    = (NW0 > lras_pkg::SIZE_W) ? NW0 : lras_pkg::SIZE_W;
   localparam int SDEP  = $clog2(MAX_ELEMENTS) + 2;
   localparam int SIW   = $clog2(SDEP);
   localparam int SPW   = $clog2(SDEP + 1);
   localparam int VW    = lras_pkg::VALUE_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_VISIT, S_COVER, S_PEND, S_CHILD, S_PCLR,
      S_FIX0, S_FIX1, S_RETURN, S_DONE
   } state_type;

   typedef enum logic [1:0] {PH_ENTER, PH_LEFT, PH_RIGHT, PH_FIX} phase_type;

   typedef struct packed {
      logic [NW-1:0] lo;
      logic [NW-1:0] hi;
      logic [AW-1:0] id;
      phase_type     phase;
   } frame_type;

   state_type         state_ff;
   frame_type         cur_ff;
   frame_type         stack_ff [SDEP];
   logic [SPW-1:0]    sp_ff;
   logic [AW-1:0]     clr_ff;
   lras_pkg::req_type req_ff;
   logic [VW-1:0]     prod_ff, p_ff, s0_ff, acc_ff;
   logic              child_ff;
   logic [lras_pkg::SIZE_W-1:0] size_ff;

   logic [VW-1:0] sum_mem  [DEPTH];
   logic [VW-1:0] pend_mem [DEPTH];
   logic [VW-1:0] sum_q, pend_q;
   logic [AW-1:0] rd_addr;
   logic          sum_we, pend_we;
   logic [AW-1:0] sum_wa, pend_wa;
   logic [VW-1:0] sum_wd, pend_wd;

   // ---- configuration ----
   assign pready = 1'b1;
   assign prdata = {{(32 - lras_pkg::SIZE_W){1'b0}}, size_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= lras_pkg::SIZE_W'(1024);
      end else if (psel && penable && pwrite && paddr == lras_pkg::CSR_SIZE_ADDR) begin
         size_ff <= pwdata[lras_pkg::SIZE_W-1:0];
      end
   end

   // ---- derived node values ----
   logic [NW-1:0] size_ext, n_eff, r_ext, l_ext, mid, cnt_full, cnt_left, cnt_right;
   logic [NW:0]   lohi;
   logic [AW-1:0] id_l, id_r;
   logic          bad, covered, is_add;

   assign size_ext  = NW'(size_ff);
   assign n_eff     = (size_ext > NW'(MAX_ELEMENTS)) ? NW'(MAX_ELEMENTS) : size_ext;
   assign r_ext     = NW'(req_data.right_index);
   assign bad       = (n_eff == '0) || (req_data.left_index > req_data.right_index) ||
                      (r_ext >= n_eff);
   assign l_ext     = NW'(req_ff.left_index);
   assign lohi      = {1'b0, cur_ff.lo} + {1'b0, cur_ff.hi};
   assign mid       = lohi[NW:1];
   assign cnt_full  = cur_ff.hi - cur_ff.lo + NW'(1);
   assign cnt_left  = mid - cur_ff.lo + NW'(1);
   assign cnt_right = cur_ff.hi - mid;
   assign id_l      = {cur_ff.id[AW-2:0], 1'b0};
   assign id_r      = {cur_ff.id[AW-2:0], 1'b1};
   assign covered   = (l_ext <= cur_ff.lo) && (cur_ff.hi <= NW'(req_ff.right_index));
   assign is_add    = (req_ff.opcode == lras_pkg::OP_ADD);
   assign busy      = (state_ff != S_IDLE);

   // ---- node memory ports ----
   always_comb begin
      rd_addr = cur_ff.id;
      sum_we  = 1'b0;
      pend_we = 1'b0;
      sum_wa  = cur_ff.id;
      pend_wa = cur_ff.id;
      sum_wd  = sum_q + prod_ff;
      pend_wd = pend_q + req_ff.increment;
      case (state_ff)
         S_CLEAR: begin
            sum_we  = 1'b1;
            pend_we = 1'b1;
            sum_wa  = clr_ff;
            pend_wa = clr_ff;
            sum_wd  = '0;
            pend_wd = '0;
         end
         S_VISIT: begin
            if (cur_ff.phase == PH_FIX) rd_addr = id_l;
         end
         S_COVER: begin
            sum_we  = is_add;
            pend_we = is_add;
         end
         S_PEND: rd_addr = id_l;
         S_CHILD: begin
            sum_we  = 1'b1;
            pend_we = 1'b1;
            sum_wa  = child_ff ? id_r : id_l;
            pend_wa = child_ff ? id_r : id_l;
            pend_wd = pend_q + p_ff;
            rd_addr = id_r;
         end
         S_PCLR: begin
            pend_we = 1'b1;
            pend_wd = '0;
         end
         S_FIX0: rd_addr = id_r;
         S_FIX1: begin
            sum_we = 1'b1;
            sum_wd = s0_ff + sum_q;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_wa] <= sum_wd;
      sum_q <= sum_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pend_we) pend_mem[pend_wa] <= pend_wd;
      pend_q <= pend_mem[rd_addr];
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         sp_ff     <= '0;
         rsp_valid <= 1'b0;
         child_ff  <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  if (bad) begin
                     rsp_valid <= 1'b1;
                     rsp_data  <= '{range_sum: '0, status: lras_pkg::STATUS_BAD};
                  end else begin
                     req_ff   <= req_data;
                     acc_ff   <= '0;
                     sp_ff    <= '0;
                     cur_ff   <= '{lo: NW'(0), hi: n_eff - NW'(1), id: AW'(1),
                                  phase: PH_ENTER};
                     state_ff <= S_VISIT;
                  end
               end
            end
            S_VISIT: begin
               unique case (cur_ff.phase)
                  PH_ENTER: begin
                     prod_ff  <= req_ff.increment * VW'(cnt_full);
                     state_ff <= covered ? S_COVER : S_PEND;
                  end
                  PH_LEFT: begin
                     if (l_ext <= mid) begin
                        stack_ff[sp_ff[SIW-1:0]] <= '{lo: cur_ff.lo, hi: cur_ff.hi,
                                                      id: cur_ff.id, phase: PH_RIGHT};
                        sp_ff  <= sp_ff + SPW'(1);
                        cur_ff <= '{lo: cur_ff.lo, hi: mid, id: id_l, phase: PH_ENTER};
                     end else begin
                        cur_ff.phase <= PH_RIGHT;
                     end
                  end
                  PH_RIGHT: begin
                     if (NW'(req_ff.right_index) > mid) begin
                        stack_ff[sp_ff[SIW-1:0]] <= '{lo: cur_ff.lo, hi: cur_ff.hi,
                                                      id: cur_ff.id, phase: PH_FIX};
                        sp_ff  <= sp_ff + SPW'(1);
                        cur_ff <= '{lo: mid + NW'(1), hi: cur_ff.hi, id: id_r,
                                    phase: PH_ENTER};
                     end else begin
                        cur_ff.phase <= PH_FIX;
                     end
                  end
                  PH_FIX: state_ff <= is_add ? S_FIX0 : S_RETURN;
                  default: state_ff <= S_RETURN;
               endcase
            end
            S_COVER: begin
               if (!is_add) acc_ff <= acc_ff + sum_q;
               state_ff <= S_RETURN;
            end
            S_PEND: begin
               p_ff     <= pend_q;
               prod_ff  <= pend_q * VW'(cnt_left);
               child_ff <= 1'b0;
               if (pend_q != '0) begin
                  state_ff <= S_CHILD;
               end else begin
                  cur_ff.phase <= PH_LEFT;
                  state_ff     <= S_VISIT;
               end
            end
            S_CHILD: begin
               if (!child_ff) begin
                  child_ff <= 1'b1;
                  prod_ff  <= p_ff * VW'(cnt_right);
               end else begin
                  state_ff <= S_PCLR;
               end
            end
            S_PCLR: begin
               cur_ff.phase <= PH_LEFT;
               state_ff     <= S_VISIT;
            end
            S_FIX0: begin
               s0_ff    <= sum_q;
               state_ff <= S_FIX1;
            end
            S_FIX1: state_ff <= S_RETURN;
            S_RETURN: begin
               if (sp_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  cur_ff   <= stack_ff[SIW'(sp_ff - SPW'(1))];
                  sp_ff    <= sp_ff - SPW'(1);
                  state_ff <= S_VISIT;
               end
            end
            S_DONE: begin
               rsp_valid <= 1'b1;
               rsp_data  <= '{range_sum: is_add ? VW'(0) : acc_ff,
                              status: lras_pkg::STATUS_OK};
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- dv/lazy_range_add_range_sum_tb.sv -----
// ----------------------------------------------------------------------------
// lazy_range_add_range_sum_tb
// Drives range adds and range sum queries into the lazy segment tree block,
// predicts each result with a flat array model, and checks every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lazy_range_add_range_sum_tb;

   localparam int MAX_EL = 1024;

   // Flat element view; lazy tree sums equal plain element sums while the
   // size stays fixed between resets.
   class range_sum_board;
      logic [63:0] elem [MAX_EL];
      int          size_n;
      lras_pkg::rsp_type pending_q [$];
      int          errors;

      function new();
         foreach (elem[i]) elem[i] = '0;
         size_n = 1024;
         errors = 0;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void note_req(lras_pkg::req_type rq);
         lras_pkg::rsp_type rs;
         int      n;
         logic [63:0] acc;
         n = (size_n > MAX_EL) ? MAX_EL : size_n;
         rs.range_sum = '0;
         rs.status = lras_pkg::STATUS_OK;
         acc = '0;
         if (n == 0 || rq.left_index > rq.right_index || rq.right_index >= n) begin
            rs.status = lras_pkg::STATUS_BAD;
         end else if (rq.opcode == lras_pkg::OP_ADD) begin
            for (int i = rq.left_index; i <= rq.right_index; i++)
               elem[i] += rq.increment;
         end else begin
            for (int i = rq.left_index; i <= rq.right_index; i++)
               acc += elem[i];
            rs.range_sum = acc;
         end
         pending_q.push_back(rs);
      endfunction

      task check_rsp(lras_pkg::rsp_type got);
         lras_pkg::rsp_type want;
         if (pending_q.size() == 0) begin
            report_mismatch("result beat with nothing pending");
            return;
         end
         want = pending_q.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.range_sum !== want.range_sum)
            report_mismatch($sformatf("range_sum got %h want %h",
                                      got.range_sum, want.range_sum));
      endtask
   endclass

   logic    clock, reset, start, psel, penable, pwrite;
   logic [lras_pkg::CSR_AW-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic    busy, rsp_valid, pready;
   lras_pkg::req_type req_data;
   lras_pkg::rsp_type rsp_data;
   range_sum_board board;
   int      gap_pct;
   int      cur_size;

   lazy_range_add_range_sum dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   initial begin
      #200ms;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_valid) board.check_rsp(rsp_data);

   // start stays high after a beat unless the sender idles; drain drops it
   task send_req(lras_pkg::req_type rq);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < gap_pct) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_req(rq);
   endtask

   task drain;
      start <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task write_size(int value);
      drain();
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= lras_pkg::CSR_SIZE_ADDR; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      board.size_n = value & 32'h7FF;
      cur_size = value & 32'h7FF;
      @(posedge clock);
   endtask

   function automatic lras_pkg::req_type mk(logic op, int l, int r, logic [63:0] inc);
      lras_pkg::req_type rq;
      rq.opcode = op;
      rq.left_index = l[9:0];
      rq.right_index = r[9:0];
      rq.increment = inc;
      return rq;
   endfunction

   function automatic lras_pkg::req_type rand_req();
      int n, l, r, w;
      logic [63:0] inc;
      n = (cur_size < 1) ? 1 : ((cur_size > MAX_EL) ? MAX_EL : cur_size);
      inc = {$urandom, $urandom};
      if ($urandom_range(3) == 0) inc = 64'($signed($urandom_range(20)) - 10);
      if ($urandom_range(15) == 0) begin
         // broken range or out of bounds
         return mk(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
                   inc);
      end
      l = $urandom_range(n - 1);
      w = ($urandom_range(3) == 0) ? $urandom_range(n - 1 - l) : $urandom_range(8);
      r = (l + w > n - 1) ? n - 1 : l + w;
      if ($urandom_range(7) == 0) inc = $urandom_range(1) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                         : 64'h8000_0000_0000_0000;
      return mk(1'($urandom_range(1)), l, r, inc);
   endfunction

   task run_random(int count);
      for (int i = 0; i < count; i++) send_req(rand_req());
   endtask

   initial begin
      board = new();
      reset = 1'b1; start = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      gap_pct = 0; cur_size = 1024;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, both operations, bad ranges
      send_req(mk(lras_pkg::OP_ADD, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF));
      send_req(mk(lras_pkg::OP_ADD, 1023, 1023, 64'h8000_0000_0000_0000));
      send_req(mk(lras_pkg::OP_ADD, 0, 1023, 64'hFFFF_FFFF_FFFF_FFFF));
      send_req(mk(lras_pkg::OP_SUM, 0, 1023, 64'h0));
      send_req(mk(lras_pkg::OP_SUM, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
      send_req(mk(lras_pkg::OP_SUM, 1023, 1023, 64'h0));
      send_req(mk(lras_pkg::OP_ADD, 5, 4, 64'd7));
      send_req(mk(lras_pkg::OP_SUM, 1023, 0, 64'd0));
      send_req(mk(lras_pkg::OP_ADD, 341, 682, 64'h5555_AAAA_5555_AAAA));
      send_req(mk(lras_pkg::OP_SUM, 300, 700, 64'd0));
      send_req(mk(lras_pkg::OP_SUM, 511, 512, 64'd0));

      // size changes: zero, one, above max, max; node stores kept
      write_size(0);
      send_req(mk(lras_pkg::OP_ADD, 0, 0, 64'd1));
      send_req(mk(lras_pkg::OP_SUM, 0, 0, 64'd0));
      write_size(1);
      // reinterpretation of stores under a new layout is not modeled by the
      // flat view, so only state written since this size counts: tree was
      // rebuilt by reset semantics only at reset; use a fresh reset-free trick
      // by clearing via the flat view when size changes is not possible, so
      // restrict checks to bad ranges at sizes zero and one.
      send_req(mk(lras_pkg::OP_ADD, 0, 1, 64'd3));
      write_size(2047);
      send_req(mk(lras_pkg::OP_SUM, 0, 1023, 64'd0));
      write_size(1024);

      gap_pct = 26; run_random(650);
      gap_pct = 72; run_random(650);
      drain();
      gap_pct = 0; run_random(650);

      drain();
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ----- lazy_range_add_range_sum.f -----
rtl/lras_pkg.sv
rtl/lazy_range_add_range_sum.sv
dv/lazy_range_add_range_sum_tb.sv
